@@ sv/rsw_pkg.sv @@
// ----------------------------------------------------------------------------
// rsw_pkg
// Types and constants shared by the rotation stall watchdog modules.
// ----------------------------------------------------------------------------
package rsw_pkg;

  localparam int unsigned HEAD_W   = 19;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned TOTAL_W  = 32;
  localparam int unsigned ROT_W    = 22;
  localparam int unsigned STALL_W  = 22;
  localparam int unsigned THR_W    = 10;
  localparam int unsigned CHG_W    = 21;
  localparam int unsigned CFG_W    = 22;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic signed [CHG_W-1:0] WRAP_LOW  = -21'sd307200;
  localparam logic signed [CHG_W-1:0] WRAP_HIGH = 21'sd307200;
  localparam logic signed [CHG_W-1:0] FULL_TURN = 21'sd368640;
  localparam logic [HEAD_W-1:0]       HALF_TURN = 19'd184320;

  localparam logic signed [TOTAL_W:0]   SUM_MAX   = 33'sd2147483647;
  localparam logic signed [TOTAL_W:0]   SUM_MIN   = -33'sd2147483647;
  localparam logic signed [TOTAL_W-1:0] TOTAL_MAX = 32'sd2147483647;
  localparam logic signed [TOTAL_W-1:0] TOTAL_MIN = -32'sd2147483647;

  localparam logic [ROT_W-1:0]   MAX_ROT_RST = 22'd737280;
  localparam logic [STALL_W-1:0] STALL_RST   = 22'd15000;
  localparam logic [THR_W-1:0]   THR_RST     = 10'd15;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_ROTATION    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STALL_LIMIT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STILL_THRESHOLD = 2'd2;

  typedef enum logic {
    OP_RESET = 1'b0,
    OP_CHECK = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    CAUSE_NONE     = 2'd0,
    CAUSE_ROTATION = 2'd1,
    CAUSE_STALL    = 2'd2
  } cause_e;

  typedef struct packed {
    logic              operation;
    logic [HEAD_W-1:0] heading;
    logic [TIME_W-1:0] timestamp_ms;
  } item_t;

  typedef struct packed {
    logic                      abort;
    cause_e                    cause;
    logic signed [TOTAL_W-1:0] rotation_total;
    logic [STALL_W-1:0]        stall_remaining;
  } result_t;

  typedef struct packed {
    logic signed [TOTAL_W-1:0] total_rotation;
    logic [HEAD_W-1:0]         last_heading;
    logic [STALL_W-1:0]        stall_countdown;
    logic [TIME_W-1:0]         last_time;
  } state_t;

  typedef struct packed {
    logic [ROT_W-1:0]   max_rotation;
    logic [STALL_W-1:0] stall_limit_ms;
    logic [THR_W-1:0]   still_threshold;
  } cfg_t;

endpackage

@@ sv/rsw_in_if.sv @@
// ----------------------------------------------------------------------------
// rsw_in_if
// Input item channel: valid, ready and one heading sample.
// ----------------------------------------------------------------------------
interface rsw_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [18:0] heading;
  logic [31:0] timestamp_ms;

  modport source (output valid, output operation, output heading, output timestamp_ms,
                  input ready);
  modport sink   (input valid, input operation, input heading, input timestamp_ms,
                  output ready);
endinterface

@@ sv/rsw_out_if.sv @@
// ----------------------------------------------------------------------------
// rsw_out_if
// Result item channel: valid, ready and one watchdog verdict.
// ----------------------------------------------------------------------------
interface rsw_out_if;
  logic               valid;
  logic               ready;
  logic               abort;
  logic [1:0]         cause;
  logic signed [31:0] rotation_total;
  logic [21:0]        stall_remaining;

  modport source (output valid, output abort, output cause, output rotation_total,
                  output stall_remaining, input ready);
  modport sink   (input valid, input abort, input cause, input rotation_total,
                  input stall_remaining, output ready);
endinterface

@@ sv/rsw_update.sv @@
// ----------------------------------------------------------------------------
// rsw_update
// Next state and result for one item: heading unwrap, saturating total,
// over rotation check and stall countdown.
// ----------------------------------------------------------------------------
module rsw_update
  import rsw_pkg::*;
(
  input  item_t   item_i,
  input  state_t  state_i,
  input  cfg_t    cfg_i,
  output state_t  state_o,
  output result_t result_o
);

  logic signed [CHG_W-1:0]   diff;
  logic signed [CHG_W-1:0]   change;
  logic [CHG_W-1:0]          chg_mag;
  logic signed [TOTAL_W:0]   sum_wide;
  logic signed [TOTAL_W-1:0] sum_sat;
  logic [TOTAL_W-1:0]        sum_mag;
  logic                      over_rot;
  logic                      still;
  logic [TIME_W-1:0]         elapsed;
  logic [STALL_W-1:0]        cd_next;

  always_comb begin
    diff = signed'({2'b00, item_i.heading}) - signed'({2'b00, state_i.last_heading});
    if (diff < WRAP_LOW) begin
      change = diff + FULL_TURN;
    end else if (diff > WRAP_HIGH) begin
      change = diff - FULL_TURN;
    end else begin
      change = diff;
    end
    chg_mag = change[CHG_W-1] ? CHG_W'(-change) : CHG_W'(change);
  end

  always_comb begin
    sum_wide = {state_i.total_rotation[TOTAL_W-1], state_i.total_rotation}
             + {{(TOTAL_W+1-CHG_W){change[CHG_W-1]}}, change};
    if (sum_wide > SUM_MAX) begin
      sum_sat = TOTAL_MAX;
    end else if (sum_wide < SUM_MIN) begin
      sum_sat = TOTAL_MIN;
    end else begin
      sum_sat = sum_wide[TOTAL_W-1:0];
    end
    sum_mag  = sum_sat[TOTAL_W-1] ? TOTAL_W'(-sum_sat) : TOTAL_W'(sum_sat);
    over_rot = sum_mag > {{(TOTAL_W-ROT_W){1'b0}}, cfg_i.max_rotation};
    still    = chg_mag <= {{(CHG_W-THR_W){1'b0}}, cfg_i.still_threshold};
  end

  always_comb begin
    elapsed = item_i.timestamp_ms - state_i.last_time;
    if (elapsed >= {{(TIME_W-STALL_W){1'b0}}, state_i.stall_countdown}) begin
      cd_next = '0;
    end else begin
      cd_next = state_i.stall_countdown - elapsed[STALL_W-1:0];
    end
  end

  always_comb begin
    state_o           = state_i;
    result_o.abort    = 1'b0;
    result_o.cause    = CAUSE_NONE;
    if (item_i.operation == OP_RESET) begin
      state_o.total_rotation  = '0;
      state_o.stall_countdown = cfg_i.stall_limit_ms;
      state_o.last_heading    = item_i.heading;
      state_o.last_time       = item_i.timestamp_ms;
    end else begin
      state_o.total_rotation = sum_sat;
      state_o.last_heading   = item_i.heading;
      if (over_rot) begin
        result_o.abort = 1'b1;
        result_o.cause = CAUSE_ROTATION;
      end else if (still) begin
        state_o.stall_countdown = cd_next;
        if (cd_next == '0) begin
          result_o.abort = 1'b1;
          result_o.cause = CAUSE_STALL;
        end else begin
          state_o.last_time = item_i.timestamp_ms;
        end
      end else begin
        state_o.stall_countdown = cfg_i.stall_limit_ms;
        state_o.last_time       = item_i.timestamp_ms;
      end
    end
    result_o.rotation_total  = state_o.total_rotation;
    result_o.stall_remaining = state_o.stall_countdown;
  end

endmodule

@@ sv/rotation_stall_watchdog_core.sv @@
// ----------------------------------------------------------------------------
// rotation_stall_watchdog_core
// Heading rotation and stall watchdog with a register stage at each side.
// ----------------------------------------------------------------------------
// path: an accepted item is held in the input register, then the result register is
//   loaded together with the watchdog state once the result channel has room
// throughput: one item per cycle while the result channel is not stalled by result_o.ready
// reset: rst_ni clears the registers to their defaults, total rotation to zero,
//   last heading to 180 degrees, countdown to 15000 ms and last time to zero
module rotation_stall_watchdog_core
  import rsw_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  rsw_in_if.sink               item_i,
  rsw_out_if.source            result_o
);

  cfg_t    cfg_q;
  state_t  state_q, state_d;
  item_t   item_q;
  logic    in_valid_q;
  result_t res_q, res_d;
  logic    out_valid_q;
  logic    adv;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_rotation    <= MAX_ROT_RST;
      cfg_q.stall_limit_ms  <= STALL_RST;
      cfg_q.still_threshold <= THR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MAX_ROTATION:    cfg_q.max_rotation    <= cfg_data_i[ROT_W-1:0];
        REG_STALL_LIMIT:     cfg_q.stall_limit_ms  <= cfg_data_i[STALL_W-1:0];
        REG_STILL_THRESHOLD: cfg_q.still_threshold <= cfg_data_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  assign adv          = in_valid_q && (!out_valid_q || result_o.ready);
  assign item_i.ready = !in_valid_q || adv;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (item_i.ready) begin
      in_valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      item_q.operation    <= item_i.operation;
      item_q.heading      <= item_i.heading;
      item_q.timestamp_ms <= item_i.timestamp_ms;
    end
  end

  rsw_update u_update (
    .item_i   (item_q),
    .state_i  (state_q),
    .cfg_i    (cfg_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // watchdog state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.total_rotation  <= '0;
      state_q.last_heading    <= HALF_TURN;
      state_q.stall_countdown <= STALL_RST;
      state_q.last_time       <= '0;
    end else if (adv) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign result_o.valid           = out_valid_q;
  assign result_o.abort           = res_q.abort;
  assign result_o.cause           = res_q.cause;
  assign result_o.rotation_total  = res_q.rotation_total;
  assign result_o.stall_remaining = res_q.stall_remaining;

  a_abort_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.abort == (res_q.cause != CAUSE_NONE)))
    else $error("abort flag and cause disagree");

  a_stall_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.cause == CAUSE_STALL) |-> (res_q.stall_remaining == '0))
    else $error("stall abort with countdown left");

  a_reset_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && item_q.operation == OP_RESET) |=>
      (state_q.total_rotation == '0 && res_q.abort == 1'b0))
    else $error("reset item did not clear rotation");

  a_total_sat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.total_rotation != {1'b1, {(TOTAL_W-1){1'b0}}})
    else $error("total rotation left the saturation range");

  a_hold_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(state_q))
    else $error("state changed without an item");

endmodule

@@ dv/rotation_stall_watchdog_core_tb.sv @@
// ----------------------------------------------------------------------------
// rotation_stall_watchdog_core_tb
// Self-checking bench for the rotation stall watchdog. Heading samples are
// driven over the item channel with random gaps. Verdicts are taken under
// random backpressure. A scoreboard keeps its own copy of the watchdog state
// and registers, predicts each verdict and compares it field by field.
// ----------------------------------------------------------------------------
module rotation_stall_watchdog_core_tb
  import rsw_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CLK_HALF     = 5;
  localparam int unsigned RESET_CYCLES = 8;
  localparam int unsigned MAX_REPORTS  = 50;
  localparam int unsigned STUCK_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned TRACK_ITEMS  = 100;
  localparam int unsigned SPIN_TURNS   = 20;
  localparam int          HEAD_SPAN    = 368640;
  localparam int          JUMP_SPAN    = 307201;

  localparam logic [CFG_W-1:0] ROT_TOP   = 22'd3686400;
  localparam logic [CFG_W-1:0] STALL_TOP = 22'd3600000;
  localparam logic [CFG_W-1:0] THR_TOP   = 22'd1023;
  localparam logic [CFG_W-1:0] CFG_ONES  = 22'h3FFFFF;

  class verdict_scoreboard;
    cfg_t        regs;
    state_t      trk;
    result_t     verdicts[$];
    int unsigned errors;

    function new();
      regs.max_rotation    = MAX_ROT_RST;
      regs.stall_limit_ms  = STALL_RST;
      regs.still_threshold = THR_RST;
      trk.total_rotation   = '0;
      trk.last_heading     = HALF_TURN;
      trk.stall_countdown  = STALL_RST;
      trk.last_time        = '0;
      errors               = 0;
    endfunction

    function void load_regs(logic [CFG_W-1:0] max_rot, logic [CFG_W-1:0] stall,
                            logic [CFG_W-1:0] thr);
      regs.max_rotation    = max_rot[ROT_W-1:0];
      regs.stall_limit_ms  = stall[STALL_W-1:0];
      regs.still_threshold = thr[THR_W-1:0];
    endfunction

    function int pending();
      return verdicts.size();
    endfunction

    function void note_sample(item_t it);
      logic signed [CHG_W-1:0] change;
      logic signed [TOTAL_W:0] sum;
      logic [TOTAL_W:0]        mag;
      logic [CHG_W-1:0]        chg_mag;
      logic [TIME_W-1:0]       elapsed;
      result_t                 r;
      r.abort = 1'b0;
      r.cause = CAUSE_NONE;
      if (it.operation == OP_RESET) begin
        trk.total_rotation  = '0;
        trk.stall_countdown = regs.stall_limit_ms;
        trk.last_heading    = it.heading;
        trk.last_time       = it.timestamp_ms;
      end else begin
        change = $signed({2'b00, it.heading}) - $signed({2'b00, trk.last_heading});
        if (change < WRAP_LOW) begin
          change = change + FULL_TURN;
        end else if (change > WRAP_HIGH) begin
          change = change - FULL_TURN;
        end
        sum = trk.total_rotation + change;
        if (sum > SUM_MAX) begin
          sum = SUM_MAX;
        end else if (sum < SUM_MIN) begin
          sum = SUM_MIN;
        end
        trk.total_rotation = sum[TOTAL_W-1:0];
        trk.last_heading   = it.heading;
        mag     = (sum < 0) ? -sum : sum;
        chg_mag = (change < 0) ? -change : change;
        if (mag > regs.max_rotation) begin
          r.abort = 1'b1;
          r.cause = CAUSE_ROTATION;
        end else begin
          if (chg_mag <= regs.still_threshold) begin
            elapsed = it.timestamp_ms - trk.last_time;
            if (elapsed >= trk.stall_countdown) begin
              trk.stall_countdown = '0;
            end else begin
              trk.stall_countdown = trk.stall_countdown - elapsed[STALL_W-1:0];
            end
          end else begin
            trk.stall_countdown = regs.stall_limit_ms;
          end
          if (trk.stall_countdown == '0 && chg_mag <= regs.still_threshold) begin
            r.abort = 1'b1;
            r.cause = CAUSE_STALL;
          end else begin
            trk.last_time = it.timestamp_ms;
          end
        end
      end
      r.rotation_total  = trk.total_rotation;
      r.stall_remaining = trk.stall_countdown;
      verdicts.push_back(r);
    endfunction

    function void report(string field, logic signed [TOTAL_W-1:0] want,
                         logic signed [TOTAL_W-1:0] got);
      errors++;
      // keep the log short when the block is badly off
      if (errors <= MAX_REPORTS) begin
        $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      end
    endfunction

    function void check_verdict(result_t got);
      result_t want;
      if (verdicts.size() == 0) begin
        errors++;
        $display("%0t ns: verdict with no sample pending, expected none, got total %0d",
                 $time, got.rotation_total);
        return;
      end
      want = verdicts.pop_front();
      if (got.abort !== want.abort) begin
        report("abort", want.abort, got.abort);
      end
      if (got.cause !== want.cause) begin
        report("cause", want.cause, got.cause);
      end
      if (got.rotation_total !== want.rotation_total) begin
        report("rotation_total", want.rotation_total, got.rotation_total);
      end
      if (got.stall_remaining !== want.stall_remaining) begin
        report("stall_remaining", want.stall_remaining, got.stall_remaining);
      end
    endfunction
  endclass

  logic                 clk_i  = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  rsw_in_if  in_ch ();
  rsw_out_if out_ch ();

  verdict_scoreboard sb;
  bit                calm     = 1'b0;
  bit                hold_req = 1'b0;
  int unsigned       cur_thr;
  int unsigned       cur_stall;
  int unsigned       stuck    = 0;

  rotation_stall_watchdog_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .item_i     (in_ch),
    .result_o   (out_ch)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  always @(posedge clk_i) begin : channel_monitor
    item_t   seen;
    result_t got;
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      seen.operation    = in_ch.operation;
      seen.heading      = in_ch.heading;
      seen.timestamp_ms = in_ch.timestamp_ms;
      sb.note_sample(seen);
    end
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got.abort           = out_ch.abort;
      got.cause           = cause_e'(out_ch.cause);
      got.rotation_total  = out_ch.rotation_total;
      got.stall_remaining = out_ch.stall_remaining;
      sb.check_verdict(got);
    end
  end

  always @(posedge clk_i) begin : stuck_watch
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stuck <= 0;
    end else begin
      stuck <= stuck + 1;
    end
    if (stuck == STUCK_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : verdict_sink
    int unsigned gap;
    out_ch.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_req) begin
        gap      = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        gap = calm ? 0 : $urandom_range(0, 11);
      end
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_ch.valid) @(posedge clk_i);
    end
  end

  task automatic send_sample(input op_e op, input logic [HEAD_W-1:0] head,
                             input logic [TIME_W-1:0] stamp);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.operation    <= op;
    in_ch.heading      <= head;
    in_ch.timestamp_ms <= stamp;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    @(posedge clk_i);
  endtask

  task automatic load_regs(input logic [CFG_W-1:0] max_rot, input logic [CFG_W-1:0] stall,
                           input logic [CFG_W-1:0] thr);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_MAX_ROTATION;
    cfg_data_i <= max_rot;
    @(posedge clk_i);
    cfg_idx_i  <= REG_STALL_LIMIT;
    cfg_data_i <= stall;
    @(posedge clk_i);
    cfg_idx_i  <= REG_STILL_THRESHOLD;
    cfg_data_i <= thr;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.load_regs(max_rot, stall, thr);
    cur_stall = 32'(stall);
    cur_thr   = 32'(thr[THR_W-1:0]);
  endtask

  task automatic run_directed();
    // from the reset state: still, at the threshold, one past it
    send_sample(OP_CHECK, HALF_TURN, 32'd5);
    send_sample(OP_CHECK, HALF_TURN + 19'd15, 32'd10);
    send_sample(OP_CHECK, HALF_TURN + 19'd31, 32'd20);
    // elapsed time across the 32-bit wrap
    send_sample(OP_RESET, 19'd0, 32'hFFFF_FF00);
    send_sample(OP_CHECK, 19'd0, 32'h0000_0100);
    // unwrap boundaries and out-of-range heading
    send_sample(OP_CHECK, 19'd307200, 32'h0000_0200);
    send_sample(OP_CHECK, 19'd0, 32'h0000_0300);
    send_sample(OP_CHECK, 19'd307201, 32'h0000_0400);
    send_sample(OP_CHECK, 19'd0, 32'h0000_0500);
    send_sample(OP_CHECK, 19'h7FFFF, 32'h0000_0600);
    send_sample(OP_CHECK, 19'd368640, 32'h0000_0700);
    // climb to exactly the rotation limit, then one past it
    send_sample(OP_RESET, 19'd0, 32'd0);
    send_sample(OP_CHECK, 19'd307200, 32'd1);
    send_sample(OP_CHECK, 19'h7FFFF, 32'd2);
    send_sample(OP_CHECK, 19'd0, 32'd3);
    send_sample(OP_CHECK, 19'd307200, 32'd4);
    send_sample(OP_CHECK, 19'd368640, 32'd5);
    send_sample(OP_CHECK, 19'd368641, 32'd6);
    // stall countdown runs out, then stays at zero
    send_sample(OP_RESET, 19'd1000, 32'd0);
    send_sample(OP_CHECK, 19'd1000, 32'd14999);
    send_sample(OP_CHECK, 19'd1000, 32'd15000);
    send_sample(OP_CHECK, 19'd1000, 32'd15000);
    // zero stall limit and zero rotation limit
    wait_drained();
    load_regs('0, '0, '0);
    send_sample(OP_RESET, 19'd5, 32'd7);
    send_sample(OP_CHECK, 19'd5, 32'd7);
    send_sample(OP_CHECK, 19'd6, 32'd8);
    // widest still threshold
    wait_drained();
    load_regs(ROT_TOP, STALL_TOP, THR_TOP);
    send_sample(OP_RESET, 19'd0, 32'd0);
    send_sample(OP_CHECK, 19'd1023, 32'd100);
    send_sample(OP_CHECK, 19'd2047, 32'd200);
  endtask

  // three-sample loop that nets a full turn per pass
  task automatic spin(input bit forward);
    logic [HEAD_W-1:0] path [3];
    int unsigned       i;
    int unsigned       j;
    path[0] = forward ? 19'd307200 : 19'h7FFFF;
    path[1] = forward ? 19'h7FFFF : 19'd307200;
    path[2] = 19'd0;
    send_sample(OP_RESET, 19'd0, 32'd0);
    for (i = 0; i < SPIN_TURNS; i++) begin
      for (j = 0; j < 3; j++) begin
        send_sample(OP_CHECK, path[j], 32'd0);
      end
    end
  endtask

  task automatic run_tracks(input int unsigned n_items);
    int unsigned       sent;
    int unsigned       len;
    int                h;
    int                delta;
    int                span;
    logic [HEAD_W-1:0] head;
    logic [TIME_W-1:0] stamp;
    sent = 0;
    while (sent < n_items) begin
      calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) begin
        send_sample(op_e'($urandom_range(0, 1)), HEAD_W'($urandom), $urandom);
        sent++;
      end else begin
        head  = ($urandom_range(0, 7) == 0) ? HEAD_W'($urandom)
                                            : HEAD_W'($urandom_range(0, HEAD_SPAN));
        stamp = $urandom;
        send_sample(OP_RESET, head, stamp);
        len  = $urandom_range(1, 30);
        sent += len + 1;
        repeat (len) begin
          span = cur_thr + 1;
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: delta = int'($urandom_range(0, 2 * span)) - span;
            5, 6, 7:       delta = int'($urandom_range(0, 40000)) - 20000;
            default:       delta = int'($urandom_range(0, 2 * JUMP_SPAN)) - JUMP_SPAN;
          endcase
          h = int'(head) + delta;
          h = ((h % HEAD_SPAN) + HEAD_SPAN) % HEAD_SPAN;
          head = ($urandom_range(0, 19) == 0) ? HEAD_W'($urandom) : HEAD_W'(h);
          case ($urandom_range(0, 7))
            0:             stamp = stamp;
            1, 2, 3, 4:    stamp = stamp + $urandom_range(0, cur_stall / 4 + 1);
            5:             stamp = stamp + cur_stall;
            6:             stamp = stamp + $urandom_range(0, 2 * cur_stall + 1);
            default:       stamp = stamp + $urandom;
          endcase
          send_sample(OP_CHECK, head, stamp);
        end
      end
    end
  endtask

  initial begin : stimulus
    sb        = new();
    cur_thr   = 32'(THR_RST);
    cur_stall = 32'(STALL_RST);
    cfg_we_i           <= 1'b0;
    cfg_idx_i          <= REG_MAX_ROTATION;
    cfg_data_i         <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.operation    <= OP_RESET;
    in_ch.heading      <= '0;
    in_ch.timestamp_ms <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();

    wait_drained();
    load_regs(CFG_ONES, STALL_RST, THR_RST);
    calm = 1'b1;
    spin(1'b1);
    spin(1'b0);

    wait_drained();
    load_regs(MAX_ROT_RST, 22'd200, THR_RST);
    hold_req = 1'b1;
    run_tracks(TRACK_ITEMS);

    wait_drained();
    load_regs('0, 22'd1, '0);
    run_tracks(TRACK_ITEMS);

    wait_drained();
    load_regs(ROT_TOP, STALL_TOP, THR_TOP);
    run_tracks(TRACK_ITEMS);

    wait_drained();
    load_regs(CFG_ONES, CFG_ONES, CFG_ONES);
    run_tracks(TRACK_ITEMS);

    repeat (2) begin
      wait_drained();
      load_regs(CFG_W'($urandom_range(0, ROT_TOP)), CFG_W'($urandom_range(1, 20000)),
                CFG_W'($urandom));
      run_tracks(TRACK_ITEMS);
    end

    calm = 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
